>>> hdl/krt_pkg.sv
// Shared constants, codes and types of the keyed record table.
`default_nettype none

package krt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	// command codes
	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_LIST   = 3'd1;
	localparam logic [2:0] CMD_SEARCH = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_DELETE = 3'd4;

	// result status codes
	localparam logic [2:0] STATUS_DONE    = 3'd0;
	localparam logic [2:0] STATUS_MISSING = 3'd1;
	localparam logic [2:0] STATUS_FULL    = 3'd2;
	localparam logic [2:0] STATUS_LISTED  = 3'd3;
	localparam logic [2:0] STATUS_EMPTY   = 3'd4;

	typedef struct packed {
		logic [31:0] id;
		logic [63:0] name;
		logic [63:0] phone;
	} record_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		record_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LIST_RD,
		S_EMIT,
		S_SHIFT
	} state_t;

endpackage

`default_nettype wire

>>> hdl/krt_req_if.sv
// Command channel of the keyed record table.
`default_nettype none

interface krt_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  cmd;
	logic signed [31:0] key;
	logic        [63:0] name_word;
	logic        [63:0] phone_word;

	modport source (output valid, cmd, key, name_word, phone_word, input ready);
	modport sink (input valid, cmd, key, name_word, phone_word, output ready);
endinterface

`default_nettype wire

>>> hdl/krt_rsp_if.sv
// Result channel of the keyed record table.
`default_nettype none

interface krt_rsp_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  status;
	logic signed [31:0] out_id;
	logic        [63:0] out_name;
	logic        [63:0] out_phone;
	logic               last;

	modport source (output valid, status, out_id, out_name, out_phone, last, input ready);
	modport sink (input valid, status, out_id, out_name, out_phone, last, output ready);
endinterface

`default_nettype wire

>>> hdl/krt_store.sv
// Record memory: one write port, one read port with registered read data.
`default_nettype none

module krt_store import krt_pkg::*; (
	input  logic    clk,
	input  mem_wr_t wr,
	input  mem_rd_t rd,
	output record_t rd_data
);

	record_t mem [TABLE_DEPTH];
	record_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/krt_seq.sv
// Command sequencer: shared key compare, scan/shift walker and result register.
`default_nettype none

module krt_seq import krt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp,
	output mem_wr_t wr,
	output mem_rd_t rd,
	input  record_t rd_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] chk_idx_s1;
	logic [CNT_W-1:0] sh_dst;
	logic             chk_v_s1, chk_v_d;

	logic [2:0]  cmd_q;
	logic [31:0] key_q;
	logic [63:0] phone_q;

	record_t     rec_q, rec_d;
	logic [2:0]  st_q, st_d;
	logic        last_q, last_d;
	logic        src_mem_q, src_mem_d;

	logic        out_v_q;
	record_t     out_rec_q;
	logic [2:0]  out_st_q;
	logic        out_last_q;
	logic        load_out;

	logic        accept;
	logic        out_free;
	logic        hit;
	logic        more;
	record_t     out_src;

	assign accept   = req.valid && (state_q == S_IDLE);
	assign out_free = !out_v_q || rsp.ready;
	assign hit      = chk_v_s1 && (rd_data.id == key_q);
	assign more     = idx_q < count_q;
	assign sh_dst   = chk_idx_s1 - CNT_W'(1);
	assign out_src  = src_mem_q ? rd_data : rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			chk_v_s1 <= chk_v_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		chk_idx_s1 <= idx_q;
		rec_q      <= rec_d;
		st_q       <= st_d;
		last_q     <= last_d;
		src_mem_q  <= src_mem_d;
		if (accept) begin
			cmd_q   <= req.cmd;
			key_q   <= req.key;
			phone_q <= req.phone_word;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		chk_v_d   = 1'b0;
		rec_d     = rec_q;
		st_d      = st_q;
		last_d    = last_q;
		src_mem_d = src_mem_q;
		load_out  = 1'b0;
		wr        = '0;
		rd        = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.cmd)
						CMD_APPEND: begin
							last_d    = 1'b1;
							src_mem_d = 1'b0;
							state_d   = S_EMIT;
							if (count_q >= DEPTH_CNT) begin
								rec_d = '0;
								st_d  = STATUS_FULL;
							end else begin
								wr.en         = 1'b1;
								wr.addr       = count_q[ADDR_W-1:0];
								wr.data.id    = req.key;
								wr.data.name  = req.name_word;
								wr.data.phone = req.phone_word;
								rec_d         = wr.data;
								st_d          = STATUS_DONE;
								count_d       = count_q + CNT_W'(1);
							end
						end
						CMD_LIST: begin
							idx_d = '0;
							if (count_q == '0) begin
								rec_d     = '0;
								st_d      = STATUS_EMPTY;
								last_d    = 1'b1;
								src_mem_d = 1'b0;
								state_d   = S_EMIT;
							end else begin
								state_d = S_LIST_RD;
							end
						end
						CMD_SEARCH, CMD_UPDATE, CMD_DELETE: begin
							idx_d   = '0;
							state_d = S_SCAN;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					// take the first match; the read in flight is dropped
					rec_d     = rd_data;
					st_d      = STATUS_DONE;
					last_d    = 1'b1;
					src_mem_d = 1'b0;
					idx_d     = chk_idx_s1 + CNT_W'(1);
					state_d   = S_EMIT;
					if (cmd_q == CMD_UPDATE) begin
						rec_d.phone   = phone_q;
						wr.en         = 1'b1;
						wr.addr       = chk_idx_s1[ADDR_W-1:0];
						wr.data.id    = rd_data.id;
						wr.data.name  = rd_data.name;
						wr.data.phone = phone_q;
					end
				end else if (more) begin
					rd.en   = 1'b1;
					rd.addr = idx_q[ADDR_W-1:0];
					chk_v_d = 1'b1;
					idx_d   = idx_q + CNT_W'(1);
				end else if (!chk_v_s1) begin
					rec_d     = '0;
					st_d      = STATUS_MISSING;
					last_d    = 1'b1;
					src_mem_d = 1'b0;
					state_d   = S_EMIT;
				end
			end
			S_LIST_RD: begin
				rd.en     = 1'b1;
				rd.addr   = idx_q[ADDR_W-1:0];
				st_d      = STATUS_LISTED;
				last_d    = (idx_q + CNT_W'(1)) == count_q;
				src_mem_d = 1'b1;
				idx_d     = idx_q + CNT_W'(1);
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (cmd_q == CMD_LIST && !last_q) begin
						state_d = S_LIST_RD;
					end else if (cmd_q == CMD_DELETE && st_q == STATUS_DONE) begin
						state_d = S_SHIFT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_SHIFT: begin
				// move entry j+1 down to j, one entry a cycle
				if (chk_v_s1) begin
					wr.en   = 1'b1;
					wr.addr = sh_dst[ADDR_W-1:0];
					wr.data = rd_data;
				end
				if (more) begin
					rd.en   = 1'b1;
					rd.addr = idx_q[ADDR_W-1:0];
					chk_v_d = 1'b1;
					idx_d   = idx_q + CNT_W'(1);
				end else if (!chk_v_s1) begin
					count_d = count_q - CNT_W'(1);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rec_q  <= out_src;
			out_st_q   <= st_q;
			out_last_q <= last_q;
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_v_q;
	assign rsp.status    = out_st_q;
	assign rsp.out_id    = out_rec_q.id;
	assign rsp.out_name  = out_rec_q.name;
	assign rsp.out_phone = out_rec_q.phone;
	assign rsp.last      = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count above table depth");

	a_chk_state: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_s1 |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("read check pending outside scan or shift");

	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && state_d == S_IDLE) |=>
		(count_q == $past(count_q) - CNT_W'(1)))
		else $error("delete did not drop the entry count");

	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && state_q == S_IDLE) |-> (req.valid && req.cmd == CMD_APPEND))
		else $error("memory written while idle without an append");

endmodule

`default_nettype wire

>>> hdl/keyed_record_table_core.sv
// Keyed record table top level: sequencer and record memory.
//
// Usage: commands arrive as words on req (cmd, key, name_word, phone_word);
// results leave as words on rsp (status, out_id, out_name, out_phone, last).
// A word moves on a rising edge with valid and ready both high. req.ready is
// high only while the sequencer is idle, so one command is worked at a time.
// Records stay compacted in entries 0 .. count-1 of a single-port-read memory;
// one shared key comparator checks one entry per cycle.
// A search, update or delete scans from entry 0 up to its first match, or
// through all entries on a miss. After its result, a delete shifts the
//   entries above the match down, one entry moved down per cycle through
//   the memory's one write port.
// Each command ends with last set on its final result; unused codes give
// no result and return to idle at once.
// Reset clears the state, the entry count and the valid flags; record contents are
// not cleared and are only read below the count. When rsp stalls, the
// result register holds its word and the sequencer waits before loading
// the next one; nothing is dropped.
`default_nettype none

module keyed_record_table_core import krt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp
);

	mem_wr_t wr;
	mem_rd_t rd;
	record_t rd_data;

	// command walker, comparator and result register
	krt_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// record storage, read data registered
	krt_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

>>> tb/tb_keyed_record_table_core.sv
// Self-checking testbench for the keyed record table: directed and random command traffic.
`default_nettype none

module tb_keyed_record_table_core import krt_pkg::*; ();

	// Command codes the block must ignore: no result word, no change of state.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	localparam int MAX_WAIT     = 18;        // longest gap or stall drawn per word
	localparam int MIXED_CMDS   = 24;        // random commands that do real work
	localparam int TAIL_CYCLES  = 200;       // covers a delete's shift after its result
	localparam int CYCLE_LIMIT  = 2_000_000; // hang guard

	// One expected word on the result channel.
	typedef struct {
		logic [2:0] status;
		record_t    rec;
		logic       last;
	} rsp_word_t;

	logic clk;
	logic arst_n;

	krt_req_if req_ch ();
	krt_rsp_if rsp_ch ();

	keyed_record_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow of the table contents: valid records sit in 0 .. shadow_count-1.
	record_t shadow_rec [TABLE_DEPTH];
	int      shadow_count;

	// Result words still owed by the block, oldest first.
	rsp_word_t due_results [$];

	// Ids that recur on purpose, so that duplicates, hits and the sign bit turn up.
	logic [31:0] key_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
		32'hffff_ffff, 32'h0000_0001, 32'hdead_beef, 32'h1234_5678, 32'h5a5a_a5a5};

	bit req_quiet;
	bit rsp_quiet;

	int cycle_count;
	int mismatch_count;
	int commands_sent;
	int results_checked;
	int listed_words;
	int full_words;
	int missing_words;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Hang guard: give up once the cycle budget is spent.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d result words still due",
			cycle_count, due_results.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic void owe_word(input logic [2:0] status, input record_t rec,
		input logic last);
		rsp_word_t w;
		w.status = status;
		w.rec    = rec;
		w.last   = last;
		due_results.push_back(w);
	endfunction

	// Apply one accepted command to the shadow table and queue the words it causes.
	function automatic void predict_table(input logic [2:0] cmd, input logic [31:0] key,
		input logic [63:0] name, input logic [63:0] phone);
		int      hit;
		record_t fresh;
		hit   = -1;
		fresh = '{id: key, name: name, phone: phone};
		case (cmd)
			CMD_APPEND: begin
				if (shadow_count >= TABLE_DEPTH) begin
					owe_word(STATUS_FULL, '0, 1'b1);
				end else begin
					shadow_rec[shadow_count] = fresh;
					shadow_count++;
					owe_word(STATUS_DONE, fresh, 1'b1);
				end
			end
			CMD_LIST: begin
				if (shadow_count == 0) begin
					owe_word(STATUS_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < shadow_count; i++)
						owe_word(STATUS_LISTED, shadow_rec[i], i == shadow_count - 1);
				end
			end
			CMD_SEARCH, CMD_UPDATE, CMD_DELETE: begin
				// first match wins; ids compare as raw bit patterns
				for (int i = 0; i < shadow_count; i++)
					if (hit < 0 && shadow_rec[i].id == key)
						hit = i;
				if (hit < 0) begin
					owe_word(STATUS_MISSING, '0, 1'b1);
				end else begin
					if (cmd == CMD_UPDATE)
						shadow_rec[hit].phone = phone;
					owe_word(STATUS_DONE, shadow_rec[hit], 1'b1);
					if (cmd == CMD_DELETE) begin
						for (int j = hit; j + 1 < shadow_count; j++)
							shadow_rec[j] = shadow_rec[j + 1];
						shadow_count--;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------

	function automatic int draw_wait(inout bit quiet);
		int n;
		n = quiet ? 0 : $urandom_range(0, MAX_WAIT);
		// flip between busy and calm stretches now and then
		if ($urandom_range(0, 24) == 0)
			quiet = !quiet;
		return n;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Ids already in the table half the time, else pooled ids, else anything at all.
	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 5);
		if (shadow_count > 0 && sel < 3)
			return shadow_rec[$urandom_range(0, shadow_count - 1)].id;
		if (sel < 5)
			return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Present one command word and hold it until the block takes it. Valid is
	// left high on return, so that a back-to-back word never drops it.
	task automatic send_command(input logic [2:0] cmd, input logic [31:0] key,
		input logic [63:0] name = '0, input logic [63:0] phone = '0);
		int gap;
		gap = draw_wait(req_quiet);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= cmd;
		req_ch.key        <= key;
		req_ch.name_word  <= name;
		req_ch.phone_word <= phone;
		do @(posedge clk); while (!req_ch.ready);
		predict_table(cmd, key, name, phone);
		commands_sent++;
	endtask

	// ------------------------------------------------------------------
	// Result side: stall at random, then compare each word taken
	// ------------------------------------------------------------------

	task automatic check_result();
		rsp_word_t want;
		if (due_results.size() == 0) begin
			$error("result word with none due: status %0d id %h", rsp_ch.status,
				rsp_ch.out_id);
			mismatch_count++;
			return;
		end
		want = due_results.pop_front();
		results_checked++;
		if (rsp_ch.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
			mismatch_count++;
		end
		if (rsp_ch.out_id !== want.rec.id) begin
			$error("out_id: expected %h, actual %h", want.rec.id, rsp_ch.out_id);
			mismatch_count++;
		end
		if (rsp_ch.out_name !== want.rec.name) begin
			$error("out_name: expected %h, actual %h", want.rec.name, rsp_ch.out_name);
			mismatch_count++;
		end
		if (rsp_ch.out_phone !== want.rec.phone) begin
			$error("out_phone: expected %h, actual %h", want.rec.phone, rsp_ch.out_phone);
			mismatch_count++;
		end
		if (rsp_ch.last !== want.last) begin
			$error("last: expected %0b, actual %0b", want.last, rsp_ch.last);
			mismatch_count++;
		end
		case (want.status)
			STATUS_LISTED:  listed_words++;
			STATUS_FULL:    full_words++;
			STATUS_MISSING: missing_words++;
			default: ;
		endcase
	endtask

	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(rsp_quiet);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			check_result();
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty table: list gives the empty status, every lookup misses, and the
	// unused codes give nothing at all.
	task automatic test_empty_table();
		send_command(CMD_LIST, 32'h0);
		send_command(CMD_SEARCH, 32'h0);
		send_command(CMD_UPDATE, 32'hffff_ffff, '0, '1);
		send_command(CMD_DELETE, 32'h8000_0000);
		for (logic [3:0] c = {1'b0, CMD_UNUSED_LO}; c <= {1'b0, CMD_UNUSED_HI}; c++)
			send_command(c[2:0], $urandom, rand64(), rand64());
		send_command(CMD_LIST, 32'hffff_ffff, '1, '1);
	endtask

	// Id, name and phone extremes, duplicate ids, update, and deletes at the
	// front, the middle and the end of the table.
	task automatic test_field_extremes();
		send_command(CMD_APPEND, 32'h8000_0000, '1, '0);
		send_command(CMD_APPEND, 32'h7fff_ffff, '0, '1);
		send_command(CMD_APPEND, 32'h0000_0000, rand64(), rand64());
		send_command(CMD_APPEND, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa,
			64'h5555_5555_5555_5555);
		// duplicate id: searches must keep finding the older record
		send_command(CMD_APPEND, 32'h7fff_ffff, rand64(), rand64());
		send_command(CMD_SEARCH, 32'h7fff_ffff);
		send_command(CMD_SEARCH, 32'h8000_0000);
		send_command(CMD_UPDATE, 32'h7fff_ffff, '1, 64'h0123_4567_89ab_cdef);
		send_command(CMD_SEARCH, 32'h7fff_ffff);
		send_command(CMD_UPDATE, 32'h1234_5678, '0, '1);
		send_command(CMD_LIST, 32'h0);
		// middle delete shifts the tail down; the duplicate then becomes the hit
		send_command(CMD_DELETE, 32'h7fff_ffff);
		send_command(CMD_SEARCH, 32'h7fff_ffff);
		send_command(CMD_DELETE, 32'h7fff_ffff);
		send_command(CMD_DELETE, 32'h8000_0000);
		send_command(CMD_DELETE, 32'h0000_0001);
		send_command(CMD_LIST, 32'h0);
	endtask

	// Fill to the brim, bounce off the full flag, list all, delete the head so
	// the whole table shifts, refill, then drop the tail entry.
	task automatic test_full_table();
		while (shadow_count < TABLE_DEPTH)
			send_command(CMD_APPEND, pick_key(), rand64(), rand64());
		send_command(CMD_APPEND, $urandom, rand64(), rand64());
		send_command(CMD_LIST, 32'h0);
		send_command(CMD_SEARCH, shadow_rec[TABLE_DEPTH - 1].id);
		send_command(CMD_UPDATE, shadow_rec[TABLE_DEPTH - 1].id, rand64(), rand64());
		send_command(CMD_DELETE, shadow_rec[0].id);
		send_command(CMD_APPEND, $urandom, rand64(), rand64());
		send_command(CMD_APPEND, $urandom, rand64(), rand64());
		send_command(CMD_DELETE, shadow_rec[TABLE_DEPTH - 1].id);
	endtask

	// Mostly well-formed traffic on keys that hit, with misses and ignored codes
	// mixed in. Hold the table below two thirds full so listings stay short.
	task automatic test_mixed_traffic();
		int sel;
		int done_cmds;
		done_cmds = 0;
		while (done_cmds < MIXED_CMDS) begin
			sel = $urandom_range(0, 99);
			if (sel >= 96) begin
				send_command(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom,
					rand64(), rand64());
			end else begin
				done_cmds++;
				if (sel < 32) begin
					if (shadow_count < 40)
						send_command(CMD_APPEND, pick_key(), rand64(), rand64());
					else
						send_command(CMD_DELETE, pick_key(), rand64(), rand64());
				end else if (sel < 40) begin
					send_command(CMD_LIST, pick_key(), rand64(), rand64());
				end else if (sel < 58) begin
					send_command(CMD_SEARCH, pick_key(), rand64(), rand64());
				end else if (sel < 72) begin
					send_command(CMD_UPDATE, pick_key(), rand64(), rand64());
				end else if (sel < 90) begin
					send_command(CMD_DELETE, pick_key(), rand64(), rand64());
				end else begin
					// stray id, almost surely absent
					send_command(CMD_SEARCH, $urandom, rand64(), rand64());
				end
			end
		end
	endtask

	// Delete every record, check the empty listing and a miss, then append one and list.
	task automatic test_drain_table();
		while (shadow_count > 0)
			send_command(CMD_DELETE, shadow_rec[$urandom_range(0, shadow_count - 1)].id);
		send_command(CMD_LIST, 32'h0);
		send_command(CMD_DELETE, pick_key());
		send_command(CMD_APPEND, 32'hffff_ffff, '1, '1);
		send_command(CMD_LIST, 32'h0);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= CMD_APPEND;
		req_ch.key        <= '0;
		req_ch.name_word  <= '0;
		req_ch.phone_word <= '0;
		shadow_count   = 0;
		req_quiet      = 1'b0;
		rsp_quiet      = 1'b0;
		cycle_count    = 0;
		mismatch_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_field_extremes();
		test_mixed_traffic();
		test_drain_table();
		test_full_table();

		// Drop valid, wait for every owed word, then give a trailing delete shift
		// time to finish so that any stray word still shows up.
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d commands and %0d result words in %0d cycles",
			commands_sent, results_checked, cycle_count);
		$display("  incl. %0d listed records, %0d table-full and %0d not-found words",
			listed_words, full_words, missing_words);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
